>>> src/tcp_sender_window_retransmit_core_defines.svh
// Assertion macros used by the TCP sender core datapath.
// Depends on nothing; included by modules that assert.
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_CORE_DEFINES_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define TSW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> src/tsw_pkg.sv
// Package for the TCP sender core: types, constants and codes.
// Depends on nothing.
package tsw_pkg;
    localparam int MaxPayload = 1000;
    localparam int QueueDepth = 64;
    localparam int QAw = $clog2(QueueDepth);
    localparam int QCw = QAw + 1;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_POLL = 2'd3
    } cmd_t;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_ISN     = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] bytes_available;
        logic        stream_closed;
        logic [31:0] ack_number;
        logic [15:0] advertised_window;
        logic [31:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic        segment_valid;
        logic [31:0] segment_seqno;
        logic        segment_syn;
        logic        segment_fin;
        logic [9:0]  segment_length;
        logic [15:0] bytes_taken;
        logic [16:0] in_flight;
        logic [7:0]  retransmissions;
        logic [31:0] next_seqno;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_CHK,
        ST_PUSH_CUT,
        ST_ACK_CHK,
        ST_ACK_RD,
        ST_ACK_POP,
        ST_TICK_ADD,
        ST_TICK_CHK,
        ST_POLL_RD,
        ST_POLL_OUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic push_init;
        logic push_cut;
        logic ack_apply;
        logic ack_pop;
        logic tick_add;
        logic tick_chk;
        logic tick_idle;
        logic poll_rd;
        logic poll_out;
        logic done;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t command;
        logic push_go;
        logic cut_more;
        logic ack_ok;
        logic ack_all;
        logic pop_more;
        logic tick_idle;
    } ctl_sts_t;

    typedef struct packed {
        logic       syn;
        logic       fin;
        logic [9:0] len;
    } info_t;

    function automatic logic [11:0] seqlen(input info_t i);
        seqlen = {2'b00, i.len} + {11'd0, i.syn} + {11'd0, i.fin};
    endfunction
endpackage

>>> src/tsw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tsw_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/tsw_ctrl.sv
// Controller state machine of the TCP sender core.
// Depends on tsw_pkg.
module tsw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tsw_pkg::ctl_sts_t sts,
    output tsw_pkg::ctl_cmd_t cmd
);
    import tsw_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (sts.command)
                        CMD_PUSH: state_next = ST_PUSH_CHK;
                        CMD_ACK:  state_next = ST_ACK_CHK;
                        CMD_TICK: state_next = ST_TICK_ADD;
                        CMD_POLL: state_next = ST_POLL_RD;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUSH_CHK:
            begin
                cmd.push_init = 1'b1;
                state_next = sts.push_go ? ST_PUSH_CUT : ST_DONE;
            end
            ST_PUSH_CUT:
            begin
                if (sts.cut_more)
                begin
                    cmd.push_cut = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ACK_CHK:
            begin
                cmd.ack_apply = 1'b1;
                state_next = (sts.ack_ok && !sts.ack_all) ? ST_ACK_RD : ST_DONE;
            end
            ST_ACK_RD:
            begin
                state_next = ST_ACK_POP;
            end
            ST_ACK_POP:
            begin
                if (sts.pop_more)
                begin
                    cmd.ack_pop = 1'b1;
                    state_next = ST_ACK_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TICK_ADD:
            begin
                if (sts.tick_idle)
                begin
                    cmd.tick_idle = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.tick_add = 1'b1;
                    state_next = ST_TICK_CHK;
                end
            end
            ST_TICK_CHK:
            begin
                cmd.tick_chk = 1'b1;
                state_next = ST_DONE;
            end
            ST_POLL_RD:
            begin
                cmd.poll_rd = 1'b1;
                state_next = ST_POLL_OUT;
            end
            ST_POLL_OUT:
            begin
                cmd.poll_out = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> src/tsw_dp.sv
// Datapath of the TCP sender core: state registers, queues and arithmetic.
// Depends on tsw_pkg, tsw_ram and the assertion macro header.
module tsw_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  tsw_pkg::in_item_t  item_in,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  tsw_pkg::ctl_cmd_t  cmd,
    output tsw_pkg::ctl_sts_t  sts,
    output logic               result_strobe,
    output tsw_pkg::out_item_t result
);
    import tsw_pkg::*;
    `include "tcp_sender_window_retransmit_core_defines.svh"

    in_item_t    in_reg;
    logic [31:0] init_to_reg, isn_reg;
    logic        started_reg, fin_sent_reg, run_reg, exp_reg;
    logic [63:0] next_abs_reg, acked_reg, ack_a_reg;
    logic [16:0] flight_reg, win_reg, remaining_reg;
    logic [15:0] wnd_reg, taken_reg;
    logic [32:0] tsum_reg;
    logic [31:0] telap_reg, cto_reg;
    logic [7:0]  retry_reg;
    logic [QAw-1:0] sq_head_reg, os_head_reg;
    logic [QCw-1:0] sq_cnt_reg, os_cnt_reg;
    logic        syn_due_reg, first_reg, cont_reg, poll_exp_reg, poll_sq_reg;
    out_item_t   res_reg;
    logic        strobe_reg;

    // Queue storage.
    logic [43:0] sq_wdata, sq_rdata;
    logic [75:0] os_wdata, os_rdata;
    logic        sq_we, os_we;
    logic [QAw-1:0] sq_waddr, os_waddr, os_raddr;

    tsw_ram #(.Width(44), .Depth(QueueDepth)) u_sq (
        .clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(sq_wdata),
        .raddr(sq_head_reg), .rdata(sq_rdata)
    );
    tsw_ram #(.Width(76), .Depth(QueueDepth)) u_os (
        .clk(clk), .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
        .raddr(os_raddr), .rdata(os_rdata)
    );

    // Ack unwrap.
    logic [31:0] off;
    logic [63:0] cand, ack_a;
    always_comb
    begin
        off = in_reg.ack_number - isn_reg;
        cand = {next_abs_reg[63:32], off};
        ack_a = cand;
        if (cand > next_abs_reg && (cand - next_abs_reg) > 64'h8000_0000
            && cand[63:32] != 32'd0)
        begin
            ack_a = cand - 64'h1_0000_0000;
        end
        else if (cand < next_abs_reg && (next_abs_reg - cand) > 64'h8000_0000)
        begin
            ack_a = cand + 64'h1_0000_0000;
        end
    end

    // Segment cutting.
    logic [16:0] room, len17;
    logic [9:0]  len;
    logic [16:0] rem_after;
    logic        seg_syn, seg_fin, full_q;
    info_t       seg_info;
    logic [63:0] seg_end;
    always_comb
    begin
        room = win_reg - flight_reg;
        len17 = (room < remaining_reg) ? room : remaining_reg;
        if (len17 > 17'(MaxPayload))
        begin
            len17 = 17'(MaxPayload);
        end
        len = len17[9:0];
        rem_after = remaining_reg - len17;
        seg_syn = syn_due_reg && first_reg;
        seg_fin = (len17 != 17'd0 && len17 == room) ? 1'b0
                : (in_reg.stream_closed && rem_after == 17'd0);
        seg_info = '{syn: seg_syn, fin: seg_fin, len: len};
        seg_end = next_abs_reg + 64'(seqlen(seg_info));
        full_q = (sq_cnt_reg >= QCw'(QueueDepth)) || (os_cnt_reg >= QCw'(QueueDepth));
    end

    logic cut_ok;
    assign cut_ok = cont_reg && (win_reg > flight_reg) && !full_q;
    assign sq_we = cmd.push_cut;
    assign os_we = cmd.push_cut;
    assign sq_waddr = QAw'(sq_head_reg + QAw'(sq_cnt_reg));
    assign os_waddr = QAw'(os_head_reg + QAw'(os_cnt_reg));
    assign sq_wdata = {len, seg_fin, seg_syn, isn_reg + next_abs_reg[31:0]};
    assign os_wdata = {seg_info, seg_end};
    assign os_raddr = os_head_reg;

    // Retired entry info.
    info_t       os_info;
    logic [63:0] os_end;
    logic [16:0] os_sl;
    assign os_info = os_rdata[75:64];
    assign os_end = os_rdata[63:0];
    assign os_sl = {5'd0, seqlen(os_info)};

    logic push_go;
    logic [16:0] win_eff;
    always_comb
    begin
        win_eff = (wnd_reg != 16'd0) ? {1'b0, wnd_reg} : 17'd1;
        push_go = !((win_eff <= flight_reg) || fin_sent_reg)
            && !(in_reg.bytes_available == 16'd0 && started_reg && !in_reg.stream_closed);
    end

    always_comb
    begin
        sts.command = cmd_t'(in_reg.command);
        sts.push_go = push_go;
        sts.cut_more = cut_ok;
        sts.ack_ok = !(ack_a < acked_reg || ack_a > next_abs_reg);
        sts.ack_all = (ack_a == next_abs_reg);
        sts.pop_more = (os_cnt_reg != '0) && (os_end <= ack_a_reg);
        sts.tick_idle = !run_reg || (os_cnt_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= item_in;
        end
        if (cmd.push_init)
        begin
            win_reg <= win_eff;
            remaining_reg <= {1'b0, in_reg.bytes_available};
            syn_due_reg <= !started_reg;
            first_reg <= 1'b1;
            cont_reg <= 1'b1;
        end
        if (cmd.push_cut)
        begin
            remaining_reg <= rem_after;
            first_reg <= 1'b0;
            cont_reg <= !(rem_after == 17'd0 || seg_fin);
        end
        if (cmd.ack_apply)
        begin
            ack_a_reg <= ack_a;
        end
        if (cmd.tick_add)
        begin
            tsum_reg <= {1'b0, telap_reg} + {1'b0, in_reg.elapsed_ms};
        end
    end

    logic [31:0] tsat;
    logic [32:0] cto2;
    assign tsat = tsum_reg[32] ? 32'hFFFF_FFFF : tsum_reg[31:0];
    assign cto2 = {cto_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_to_reg <= 32'd1000;
            isn_reg <= '0;
            started_reg <= 1'b0;
            fin_sent_reg <= 1'b0;
            next_abs_reg <= '0;
            acked_reg <= '0;
            flight_reg <= '0;
            wnd_reg <= 16'd1;
            run_reg <= 1'b0;
            exp_reg <= 1'b0;
            telap_reg <= '0;
            cto_reg <= 32'd1000;
            retry_reg <= '0;
            sq_head_reg <= '0;
            sq_cnt_reg <= '0;
            os_head_reg <= '0;
            os_cnt_reg <= '0;
            taken_reg <= '0;
            poll_exp_reg <= 1'b0;
            poll_sq_reg <= 1'b0;
            strobe_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            strobe_reg <= cmd.done;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                begin
                    init_to_reg <= cfg_data;
                    cto_reg <= cfg_data;
                end
                else
                begin
                    isn_reg <= cfg_data;
                end
            end
            if (cmd.load)
            begin
                taken_reg <= '0;
                poll_exp_reg <= 1'b0;
                poll_sq_reg <= 1'b0;
            end
            if (cmd.push_init && !(win_eff <= flight_reg || fin_sent_reg))
            begin
                started_reg <= 1'b1;
            end
            if (cmd.push_cut)
            begin
                taken_reg <= taken_reg + 16'(len);
                if (seg_fin)
                begin
                    fin_sent_reg <= 1'b1;
                end
                next_abs_reg <= seg_end;
                flight_reg <= flight_reg + {5'd0, seqlen(seg_info)};
                sq_cnt_reg <= sq_cnt_reg + QCw'(1);
                os_cnt_reg <= os_cnt_reg + QCw'(1);
            end
            if (cmd.ack_apply && sts.ack_ok)
            begin
                wnd_reg <= in_reg.advertised_window;
                if (ack_a > 64'd1)
                begin
                    telap_reg <= '0;
                    retry_reg <= '0;
                    cto_reg <= init_to_reg;
                end
                acked_reg <= ack_a;
                if (sts.ack_all)
                begin
                    flight_reg <= '0;
                    run_reg <= 1'b0;
                    os_cnt_reg <= '0;
                end
            end
            if (cmd.ack_pop)
            begin
                flight_reg <= (flight_reg >= os_sl) ? flight_reg - os_sl : '0;
                os_head_reg <= os_head_reg + QAw'(1);
                os_cnt_reg <= os_cnt_reg - QCw'(1);
            end
            if (cmd.tick_idle)
            begin
                exp_reg <= 1'b0;
                telap_reg <= '0;
                retry_reg <= '0;
            end
            if (cmd.tick_chk)
            begin
                if (tsat >= cto_reg)
                begin
                    exp_reg <= 1'b1;
                    telap_reg <= '0;
                    if (retry_reg != 8'hFF)
                    begin
                        retry_reg <= retry_reg + 8'd1;
                    end
                    if (wnd_reg != 16'd0)
                    begin
                        cto_reg <= cto2[32] ? 32'hFFFF_FFFF : cto2[31:0];
                    end
                end
                else
                begin
                    exp_reg <= 1'b0;
                    telap_reg <= tsat;
                end
            end
            if (cmd.poll_rd)
            begin
                if (exp_reg)
                begin
                    exp_reg <= 1'b0;
                    poll_exp_reg <= (os_cnt_reg != '0);
                end
                else if (sq_cnt_reg != '0)
                begin
                    poll_sq_reg <= 1'b1;
                    run_reg <= 1'b1;
                end
            end
            if (cmd.poll_out && poll_sq_reg)
            begin
                sq_head_reg <= sq_head_reg + QAw'(1);
                sq_cnt_reg <= sq_cnt_reg - QCw'(1);
            end
            if (cmd.done)
            begin
                res_reg.segment_valid <= poll_exp_reg || poll_sq_reg;
                if (poll_exp_reg)
                begin
                    res_reg.segment_seqno <= isn_reg
                        + 32'(os_end - 64'(seqlen(os_info)));
                    res_reg.segment_syn <= os_info.syn;
                    res_reg.segment_fin <= os_info.fin;
                    res_reg.segment_length <= os_info.len;
                end
                else if (poll_sq_reg)
                begin
                    res_reg.segment_seqno <= sq_rdata[31:0];
                    res_reg.segment_syn <= sq_rdata[32];
                    res_reg.segment_fin <= sq_rdata[33];
                    res_reg.segment_length <= sq_rdata[43:34];
                end
                else
                begin
                    res_reg.segment_seqno <= '0;
                    res_reg.segment_syn <= 1'b0;
                    res_reg.segment_fin <= 1'b0;
                    res_reg.segment_length <= '0;
                end
                res_reg.bytes_taken <= taken_reg;
                res_reg.in_flight <= flight_reg;
                res_reg.retransmissions <= retry_reg;
                res_reg.next_seqno <= isn_reg + next_abs_reg[31:0];
            end
        end
    end

    assign result_strobe = strobe_reg;
    assign result = res_reg;

    `TSW_ASSERT_IMP(a_sq_bound, 1'b1, sq_cnt_reg <= QCw'(QueueDepth))
    `TSW_ASSERT_IMP(a_os_bound, 1'b1, os_cnt_reg <= QCw'(QueueDepth))
    `TSW_ASSERT_NEXT(a_strobe, cmd.done, result_strobe)
    `TSW_ASSERT_IMP(a_ack_order, 1'b1, acked_reg <= next_abs_reg)
endmodule

>>> src/tcp_sender_window_retransmit_core.sv
// TCP sender core: one command item per start, one result strobe per item.
// Push cuts one segment at a time unless blocked; an ack that retires entries
// reads and checks them in turn; a tick adds, then compares unless idle; a poll
// reads, then outputs. busy falls in the strobe cycle, so the next item is taken
// at the edge that takes the result; results cannot be stalled.
// Asynchronous active-low reset clears state; timeout 1000, sequence base 0.
module tcp_sender_window_retransmit_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tsw_pkg::in_item_t  item_in,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               result_strobe,
    output tsw_pkg::out_item_t result
);
    import tsw_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;
    ctl_sts_t sts_ctl;

    always_comb
    begin
        sts_ctl = sts;
        if (!busy)
        begin
            sts_ctl.command = cmd_t'(item_in.command);
        end
    end

    tsw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sts(sts_ctl), .cmd(cmd)
    );

    tsw_dp u_dp (
        .clk(clk), .rst_n(rst_n), .item_in(item_in),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .sts(sts), .result_strobe(result_strobe), .result(result)
    );
endmodule

>>> tb/sv/tcp_sender_window_retransmit_core_test.sv
// Testbench for the TCP sender core: directed and random command items, checked
// against an in-bench predictor of the segment queues, acks and retransmit timer.
// Depends on tsw_pkg and tcp_sender_window_retransmit_core.
module tcp_sender_window_retransmit_core_test;
    import tsw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned M32 = 64'hFFFF_FFFF;
    localparam int IdleLimit = 20000;

    typedef struct {
        logic [31:0] seq;
        logic        syn;
        logic        fin;
        logic [9:0]  len;
    } queued_seg_t;

    typedef struct {
        longint unsigned seg_end;
        logic            syn;
        logic            fin;
        logic [15:0]     len;
    } unacked_seg_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_item_t    item_in = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_TIMEOUT;
    logic [31:0] cfg_data = '0;
    logic        result_strobe;
    out_item_t   result;

    tcp_sender_window_retransmit_core u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item_in(item_in),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_strobe(result_strobe),
        .result(result)
    );

    always #5 clk = ~clk;

    logic [31:0]     timeout_reg = 32'd1000;
    logic [31:0]     isn_reg = 32'd0;
    bit              started, fin_sent, tmr_running, tmr_expired;
    longint unsigned next_abs, acked_abs, flight_len;
    logic [15:0]     window_held = 16'd1;
    logic [31:0]     tmr_elapsed = 32'd0, cur_timeout = 32'd1000;
    logic [7:0]      retry_count = 8'd0;
    queued_seg_t     send_q[$];
    unacked_seg_t    unacked_q[$];

    in_item_t        pending_items[$];
    out_item_t       results_due[$];
    int              send_idle_pct = 19;
    int              items_accepted = 0;
    int              results_seen = 0;
    int              segments_seen = 0;
    int              resends_seen = 0;
    int              mismatches = 0;
    int              idle_cycles = 0;

    function automatic longint unsigned seg_span(unacked_seg_t s);
        return longint'(s.len) + s.syn + s.fin;
    endfunction

    function automatic longint unsigned unwrap_ackno(logic [31:0] ackno);
        longint unsigned off, cand;
        off = (longint'(ackno) - longint'(isn_reg)) & M32;
        cand = (next_abs & ~M32) | off;
        if (cand > next_abs && cand - next_abs > 64'h8000_0000 && cand >= 64'h1_0000_0000)
            cand -= 64'h1_0000_0000;
        else if (cand < next_abs && next_abs - cand > 64'h8000_0000)
            cand += 64'h1_0000_0000;
        return cand;
    endfunction

    function automatic logic [15:0] cut_segments(logic [15:0] avail, logic closed);
        longint unsigned win, remaining, room, len, taken;
        bit           syn_due, first, syn, fin;
        queued_seg_t  qs;
        unacked_seg_t us;
        win = (window_held > 0) ? longint'(window_held) : 1;
        if (win <= flight_len || fin_sent)
            return 16'd0;
        syn_due = !started;
        started = 1'b1;
        if (avail == 0 && !syn_due && !closed)
            return 16'd0;
        remaining = avail;
        taken = 0;
        first = 1'b1;
        while (win > flight_len) begin
            room = win - flight_len;
            len = (room < remaining) ? room : remaining;
            if (send_q.size() >= QueueDepth || unacked_q.size() >= QueueDepth)
                break;
            if (len > MaxPayload)
                len = MaxPayload;
            remaining -= len;
            taken += len;
            syn = syn_due && first;
            first = 1'b0;
            fin = (len > 0 && len == room) ? 1'b0 : (closed && remaining == 0);
            if (fin)
                fin_sent = 1'b1;
            qs.seq = 32'(longint'(isn_reg) + next_abs);
            qs.syn = syn;
            qs.fin = fin;
            qs.len = 10'(len);
            send_q.push_back(qs);
            next_abs += len + syn + fin;
            flight_len += len + syn + fin;
            us.seg_end = next_abs;
            us.syn = syn;
            us.fin = fin;
            us.len = 16'(len);
            unacked_q.push_back(us);
            if (remaining == 0 || fin)
                break;
        end
        return 16'(taken);
    endfunction

    function automatic void take_ack(logic [31:0] ackno, logic [15:0] wnd);
        longint unsigned a, sl;
        a = unwrap_ackno(ackno);
        if (a < acked_abs || a > next_abs)
            return;
        window_held = wnd;
        if (a > 1) begin
            tmr_elapsed = 0;
            retry_count = 0;
            cur_timeout = timeout_reg;
        end
        acked_abs = a;
        if (a == next_abs) begin
            flight_len = 0;
            tmr_running = 1'b0;
            unacked_q.delete();
            return;
        end
        while (unacked_q.size() > 0 && unacked_q[0].seg_end <= a) begin
            sl = seg_span(unacked_q[0]);
            flight_len = (flight_len >= sl) ? flight_len - sl : 0;
            void'(unacked_q.pop_front());
        end
    endfunction

    function automatic void run_timer(logic [31:0] ms);
        longint unsigned t;
        if (!tmr_running || unacked_q.size() == 0) begin
            tmr_expired = 1'b0;
            tmr_elapsed = 0;
            retry_count = 0;
            return;
        end
        t = longint'(tmr_elapsed) + longint'(ms);
        tmr_elapsed = (t > M32) ? 32'hFFFF_FFFF : 32'(t);
        tmr_expired = tmr_elapsed >= cur_timeout;
        if (tmr_expired) begin
            tmr_elapsed = 0;
            if (retry_count < 8'd255)
                retry_count++;
            if (window_held > 0) begin
                t = longint'(cur_timeout) * 2;
                cur_timeout = (t > M32) ? 32'hFFFF_FFFF : 32'(t);
            end
        end
    endfunction

    function automatic void add_item(in_item_t it);
        out_item_t   r;
        queued_seg_t qs;
        r = '0;
        case (cmd_t'(it.command))
            CMD_PUSH: r.bytes_taken = cut_segments(it.bytes_available, it.stream_closed);
            CMD_ACK:  take_ack(it.ack_number, it.advertised_window);
            CMD_TICK: run_timer(it.elapsed_ms);
            default: begin
                if (tmr_expired) begin
                    tmr_expired = 1'b0;
                    if (unacked_q.size() > 0) begin
                        r.segment_valid = 1'b1;
                        r.segment_seqno = 32'(longint'(isn_reg) + unacked_q[0].seg_end
                                              - seg_span(unacked_q[0]));
                        r.segment_syn = unacked_q[0].syn;
                        r.segment_fin = unacked_q[0].fin;
                        r.segment_length = unacked_q[0].len[9:0];
                    end
                end else if (send_q.size() > 0) begin
                    qs = send_q.pop_front();
                    tmr_running = 1'b1;
                    r.segment_valid = 1'b1;
                    r.segment_seqno = qs.seq;
                    r.segment_syn = qs.syn;
                    r.segment_fin = qs.fin;
                    r.segment_length = qs.len;
                end
            end
        endcase
        r.in_flight = 17'(flight_len);
        r.retransmissions = retry_count;
        r.next_seqno = 32'(longint'(isn_reg) + next_abs);
        results_due.push_back(r);
        pending_items.push_back(it);
    endfunction

    function automatic in_item_t noise_item(cmd_t cmd);
        in_item_t it;
        it.command = cmd;
        it.bytes_available = 16'($urandom);
        it.stream_closed = 1'($urandom);
        it.ack_number = $urandom;
        it.advertised_window = 16'($urandom);
        it.elapsed_ms = $urandom;
        return it;
    endfunction

    function automatic void push_item(logic [15:0] avail, logic closed);
        in_item_t it;
        it = noise_item(CMD_PUSH);
        it.bytes_available = avail;
        it.stream_closed = closed;
        add_item(it);
    endfunction

    function automatic void ack_item(longint unsigned abs_ack, logic [15:0] wnd);
        in_item_t it;
        it = noise_item(CMD_ACK);
        it.ack_number = 32'(longint'(isn_reg) + abs_ack);
        it.advertised_window = wnd;
        add_item(it);
    endfunction

    function automatic void tick_item(logic [31:0] ms);
        in_item_t it;
        it = noise_item(CMD_TICK);
        it.elapsed_ms = ms;
        add_item(it);
    endfunction

    function automatic void poll_item();
        add_item(noise_item(CMD_POLL));
    endfunction

    function automatic logic [15:0] pick_window();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'hFFFF;
        if (r < 40) return 16'($urandom);
        return 16'($urandom_range(4000, 1));
    endfunction

    function automatic void random_items(int n, bit allow_close);
        int              r, k;
        logic [15:0]     avail;
        longint unsigned a;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 25) begin
                k = $urandom_range(99);
                if (k < 40) avail = 16'($urandom_range(3000, 1));
                else if (k < 60) avail = 16'($urandom);
                else if (k < 70) avail = 16'd0;
                else if (k < 80) avail = 16'hFFFF;
                else avail = 16'($urandom_range(200, 1));
                push_item(avail, allow_close && $urandom_range(39) == 0);
            end else if (r < 55) begin
                k = $urandom_range(99);
                if (k < 15) begin
                    add_item(noise_item(CMD_ACK));
                end else begin
                    if (unacked_q.size() > 0 && k < 55)
                        a = unacked_q[$urandom_range(unacked_q.size() - 1)].seg_end;
                    else
                        a = acked_abs + $urandom_range(int'(next_abs - acked_abs));
                    ack_item(a, pick_window());
                end
            end else if (r < 75) begin
                k = $urandom_range(99);
                if (k < 50) tick_item($urandom_range(800));
                else if (k < 70) tick_item($urandom_range(5000, 1000));
                else if (k < 85) tick_item($urandom);
                else if (k < 90) tick_item(32'hFFFF_FFFF);
                else tick_item(32'd0);
            end else begin
                poll_item();
            end
        end
    endfunction

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TIMEOUT) begin
            timeout_reg = value;
            cur_timeout = value;
        end else begin
            isn_reg = value;
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || results_due.size() > 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk) begin : drive_items
        logic go;
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                void'(pending_items.pop_front());
                items_accepted++;
            end
            go = pending_items.size() > 0 && ($urandom_range(99) >= send_idle_pct);
            if (go)
                item_in <= pending_items[0];
            start <= go;
        end
    end

    always @(posedge clk) begin : check_results
        out_item_t want;
        if (rst_n) begin
            if ((start && !busy) || result_strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("Timeout: no item or result for %0d cycles", IdleLimit);
                $display("*** FAILED ***");
                $finish;
            end
            if (result_strobe) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result %p", result);
                end else begin
                    want = results_due.pop_front();
                    if (result.segment_valid) begin
                        segments_seen++;
                        if (result.retransmissions != 0) resends_seen++;
                    end
                    if (result.segment_valid !== want.segment_valid
                        || result.segment_seqno !== want.segment_seqno
                        || result.segment_syn !== want.segment_syn
                        || result.segment_fin !== want.segment_fin
                        || result.segment_length !== want.segment_length
                        || result.bytes_taken !== want.bytes_taken
                        || result.in_flight !== want.in_flight
                        || result.retransmissions !== want.retransmissions
                        || result.next_seqno !== want.next_seqno) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch at result %0d", results_seen);
                            $display("  expected %p", want);
                            $display("  actual   %p", result);
                        end
                    end
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        poll_item();
        tick_item(32'd100);
        push_item(16'd0, 1'b0);
        push_item(16'd500, 1'b0);
        poll_item();
        ack_item(next_abs + 1, 16'd3000);
        ack_item(1, 16'd3000);
        push_item(16'hFFFF, 1'b0);
        poll_item();
        poll_item();
        tick_item(32'd999);
        tick_item(32'd1);
        poll_item();
        ack_item(acked_abs, 16'd0);
        tick_item(32'hFFFF_FFFF);
        poll_item();
        ack_item(unacked_q[0].seg_end, 16'hFFFF);
        ack_item(acked_abs - 1, 16'd2000);
        push_item(16'd1000, 1'b0);
        ack_item(next_abs, 16'd0);
        push_item(16'd5, 1'b0);
        poll_item();
        ack_item(next_abs, 16'd1500);
        drain();

        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_ISN, 32'hFFFF_FFFF);
        @(negedge clk);
        random_items(90, 1'b0);
        ack_item(next_abs, 16'd2000);
        push_item(16'd100, 1'b0);
        poll_item();
        poll_item();
        for (int i = 0; i < 260; i++)
            tick_item($urandom_range(3));
        poll_item();
        ack_item(next_abs, 16'd3000);
        drain();

        send_idle_pct = 52;
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_ISN, $urandom);
        @(negedge clk);
        random_items(110, 1'b0);
        drain();

        send_idle_pct = 0;
        write_reg(CFG_TIMEOUT, $urandom_range(3000, 200));
        write_reg(CFG_ISN, 32'd0);
        @(negedge clk);
        random_items(110, 1'b1);

        while (pending_items.size() > 0 || results_due.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Ran %0d command items through four register settings.", items_accepted);
        $display("Saw %0d segments, %0d of them with retransmissions pending.",
                 segments_seen, resends_seen);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, results_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
